FILE: src/vtm_pkg.sv
package vtm_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN = 24;

   localparam int FIELD_W = 16;
   localparam int REQ_W = 9 * FIELD_W;
   localparam int RSP_W = 5 * FIELD_W;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 16;
   localparam int CUTOFF_W = 15;

   localparam int DW = 22;   // scaled demand, Q.14
   localparam int PW = 40;   // gain products
   localparam int VW = 27;   // vector components, Q.15
   localparam int CW = 38;   // CORDIC x/y datapath
   localparam int ZW = 32;   // angles, Q.28
   localparam int MPW = 49;  // magnitude times CORDIC gain
   localparam int LPW = 50;  // linkage product
   localparam int AW = 32;   // linkage argument, Q.30
   localparam int ROOT_STEPS = 31;
   localparam int RW = 2 * ROOT_STEPS - 1;

   localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314857;
   localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic [23:0] GAIN_Q24 = 24'd10188014;
   localparam logic signed [ZW-1:0] GAIN_Q30 = 32'sd652032875;
   localparam logic signed [AW-1:0] ONE_Q30 = 32'sd1073741824;
   localparam logic [FIELD_W-1:0] THRUST_MAX = 16'd32768;

   localparam logic signed [ZW-1:0] ATAN_Q28 [TABLE_LEN] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
      32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
      32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
      32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
      32'sd256, 32'sd128, 32'sd64, 32'sd32
   };

   localparam logic [15:0] GAIN_FORWARD_RST = 16'd23211;
   localparam logic [15:0] GAIN_UP_RST = 16'd20480;
   localparam logic [15:0] GAIN_ROLL_RST = 16'd6827;
   localparam logic [15:0] GAIN_YAW_RST = 16'd4096;
   localparam logic [15:0] GAIN_PITCH_RST = 16'd32768;
   localparam logic [15:0] LINKAGE_RATIO_RST = 16'd6554;
   localparam logic [15:0] REAR_OFFSET_RST = 16'd20017;
   localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 15'd655;

   typedef enum logic [CSR_IW-1:0] {
      REG_GAIN_FORWARD,
      REG_GAIN_UP,
      REG_GAIN_ROLL,
      REG_GAIN_YAW,
      REG_GAIN_PITCH,
      REG_LINKAGE_RATIO,
      REG_REAR_OFFSET,
      REG_THROTTLE_CUTOFF
   } reg_index_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } init_type;

   typedef struct packed {
      logic                  low;
      logic signed [PW-1:0]  pm;
      logic                  zero1;
      logic                  zero2;
      logic                  zero3;
      logic [MPW-1:0]        mp1;
      logic [MPW-1:0]        mp2;
      logic                  big1;
      logic                  big2;
      logic signed [ZW-1:0]  phi;
      logic signed [PW-1:0]  s1r;
      logic signed [PW-1:0]  s2r;
      logic [FIELD_W-1:0]    m1;
      logic [FIELD_W-1:0]    m2;
      logic [FIELD_W-1:0]    s1;
      logic [FIELD_W-1:0]    s2;
      logic signed [ZW-1:0]  zs;
      logic signed [LPW-1:0] lp;
      logic signed [AW-1:0]  a;
      logic [RW-1:0]         sq;
      logic [RW-1:0]         n;
   } side_type;

endpackage

FILE: src/vtm_cordic.sv
module vtm_cordic #(
   parameter int STEPS = vtm_pkg::CORDIC_STEPS_DEF,
   parameter bit ROTATE = 1'b0
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [vtm_pkg::CW-1:0] x_start,
   input  logic signed [vtm_pkg::CW-1:0] y_start,
   input  logic signed [vtm_pkg::ZW-1:0] z_start,
   output logic signed [vtm_pkg::CW-1:0] x_end,
   output logic signed [vtm_pkg::CW-1:0] y_end,
   output logic signed [vtm_pkg::ZW-1:0] z_end
);
   import vtm_pkg::*;

   logic signed [CW-1:0] x_ff [STEPS];
   logic signed [CW-1:0] y_ff [STEPS];
   logic signed [ZW-1:0] z_ff [STEPS];
   logic signed [CW-1:0] x_in [STEPS];
   logic signed [CW-1:0] y_in [STEPS];
   logic signed [ZW-1:0] z_in [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [ZW-1:0] pz;
      logic                 ccw;

      if (i == 0) begin : g_first
         assign px = x_start;
         assign py = y_start;
         assign pz = z_start;
      end else begin : g_next
         assign px = x_ff[i-1];
         assign py = y_ff[i-1];
         assign pz = z_ff[i-1];
      end

      // rotation drives z to zero, vectoring drives y to zero
      assign ccw = ROTATE ? (pz >= 0) : !(py > 0);

      always_comb begin
         if (ccw) begin
            x_in[i] = px - (py >>> i);
            y_in[i] = py + (px >>> i);
            z_in[i] = pz - ATAN_Q28[i];
         end else begin
            x_in[i] = px + (py >>> i);
            y_in[i] = py - (px >>> i);
            z_in[i] = pz + ATAN_Q28[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign x_end = x_ff[STEPS-1];
   assign y_end = y_ff[STEPS-1];
   assign z_end = z_ff[STEPS-1];

endmodule

FILE: src/vectored_thrust_mixer_core.sv
// Throughput: one request per cycle, stalled while the output skid entry is full; every CORDIC
// iteration and square root bit is its own pipeline stage, with a two-entry output buffer
// behind the last stage.
// Reset: synchronous, active high; clears all valid bits and loads the register defaults.
module vectored_thrust_mixer_core #(
   parameter int CORDIC_STEPS = vtm_pkg::CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // forward_demand, throttle_demand, roll_demand, roll_feedforward, pitch_demand,
   // pitch_feedforward, yaw_demand, yaw_feedforward, thrust_gain (16 bits each)
   input  logic [vtm_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // motor_one_thrust, motor_two_thrust, servo_one_angle, servo_two_angle,
   // servo_three_angle (16 bits each)
   output logic [vtm_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_we,
   input  logic [vtm_pkg::CSR_IW-1:0]   csr_index,
   input  logic [vtm_pkg::CSR_DW-1:0]   csr_data
);
   import vtm_pkg::*;

   localparam int S_SCALE  = 0;
   localparam int S_PROD   = S_SCALE + 1;
   localparam int S_VEC    = S_PROD + 1;
   localparam int S_SETUP  = S_VEC + 1;
   localparam int S_VCL    = S_SETUP + CORDIC_STEPS;
   localparam int S_MAG    = S_VCL + 1;
   localparam int S_THR    = S_MAG + 1;
   localparam int S_SCL    = S_THR + CORDIC_STEPS;
   localparam int S_LPROD  = S_SCL + 1;
   localparam int S_LCLAMP = S_LPROD + 1;
   localparam int S_SQ     = S_LCLAMP + 1;
   localparam int S_NRAD   = S_SQ + 1;
   localparam int S_RTL    = S_NRAD + ROOT_STEPS;
   localparam int S_ASET   = S_RTL + 1;
   localparam int S_ACL    = S_ASET + CORDIC_STEPS;
   localparam int NSTAGE   = S_ACL + 1;

   localparam logic signed [PW-1:0] SAT_HI = 40'sd32767;
   localparam logic signed [PW-1:0] SAT_LO = -40'sd32768;
   localparam logic [RW-1:0] ONE_Q60 = RW'(1) << (RW - 1);

   function automatic logic signed [DW-1:0] scale(input logic signed [16:0] d,
                                                  input logic [15:0] g);
      logic signed [33:0] p;
      p = 34'(d) * 34'($signed({1'b0, g}));
      p = p + 34'sd2048;
      return DW'(p >>> 12);
   endfunction

   function automatic logic signed [PW-1:0] gmul(input logic [15:0] k,
                                                 input logic signed [DW-1:0] v);
      logic signed [PW-1:0] ka;
      logic signed [PW-1:0] vb;
      ka = $signed({{(PW-16){1'b0}}, k});
      vb = PW'(v);
      return ka * vb;
   endfunction

   function automatic logic signed [VW-1:0] rnd14(input logic signed [PW-1:0] s);
      logic signed [PW-1:0] t;
      t = s + PW'(8192);
      return VW'(t >>> 14);
   endfunction

   function automatic init_type vec_init(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
      init_type r;
      r.x = x;
      r.y = y;
      r.z = '0;
      r.zero = (x == 0) && (y == 0);
      if (x < 0) begin
         r.z = (y >= 0) ? PI_Q28 : -PI_Q28;
         r.x = -x;
         r.y = -y;
      end
      return r;
   endfunction

   function automatic logic [MPW:0] mag_prod(input logic signed [CW-1:0] m,
                                             input logic zero);
      logic [24:0]    ml;
      logic           big;
      logic [MPW-1:0] p;
      ml = (zero || m[CW-1]) ? '0 : m[24:0];
      big = !zero && !m[CW-1] && (|m[CW-2:25]);
      p = MPW'(ml) * MPW'(GAIN_Q24);
      return {big, p};
   endfunction

   function automatic logic [FIELD_W-1:0] thrust(input logic big, input logic [MPW-1:0] p);
      logic [MPW:0]    q;
      logic [MPW-32:0] r;
      q = {1'b0, p} + ((MPW + 1)'(1) << 31);
      r = q[MPW:32];
      if (big || (r > (MPW - 31)'(THRUST_MAX))) begin
         return THRUST_MAX;
      end
      return r[FIELD_W-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] sat16(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      r = (v + PW'(32768)) >>> 16;
      if (r > SAT_HI) begin
         return 16'h7fff;
      end else if (r < SAT_LO) begin
         return 16'h8000;
      end
      return r[FIELD_W-1:0];
   endfunction

   function automatic logic signed [ZW-1:0] fold(input logic signed [ZW-1:0] z);
      if (z > HALF_PI_Q28) begin
         return PI_Q28 - z;
      end else if (z < -HALF_PI_Q28) begin
         return -PI_Q28 - z;
      end
      return z;
   endfunction

   function automatic logic signed [16:0] dsum(input logic [15:0] a, input logic [15:0] b);
      return {a[15], a} + {b[15], b};
   endfunction

   // configuration
   logic [15:0] gain_forward_ff, gain_up_ff, gain_roll_ff, gain_yaw_ff, gain_pitch_ff;
   logic [15:0] linkage_ratio_ff, rear_offset_ff;
   logic [CUTOFF_W-1:0] cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_forward_ff  <= GAIN_FORWARD_RST;
         gain_up_ff       <= GAIN_UP_RST;
         gain_roll_ff     <= GAIN_ROLL_RST;
         gain_yaw_ff      <= GAIN_YAW_RST;
         gain_pitch_ff    <= GAIN_PITCH_RST;
         linkage_ratio_ff <= LINKAGE_RATIO_RST;
         rear_offset_ff   <= REAR_OFFSET_RST;
         cutoff_ff        <= CUTOFF_RST;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_GAIN_FORWARD:    gain_forward_ff <= csr_data;
            REG_GAIN_UP:         gain_up_ff <= csr_data;
            REG_GAIN_ROLL:       gain_roll_ff <= csr_data;
            REG_GAIN_YAW:        gain_yaw_ff <= csr_data;
            REG_GAIN_PITCH:      gain_pitch_ff <= csr_data;
            REG_LINKAGE_RATIO:   linkage_ratio_ff <= csr_data;
            REG_REAR_OFFSET:     rear_offset_ff <= csr_data;
            REG_THROTTLE_CUTOFF: cutoff_ff <= csr_data[CUTOFF_W-1:0];
         endcase
      end
   end

   // pipeline control
   logic              advance;
   logic [NSTAGE-1:0] v_ff;
   logic              out_v_ff, skid_v_ff;
   logic [RSP_W-1:0]  out_ff, skid_ff, result;

   assign advance = !skid_v_ff;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[NSTAGE-2:0], req_tvalid};
      end
   end

   // early stages
   logic signed [DW-1:0] fx_ff, fz_ff, mx_ff, my_ff, mz_ff;
   logic signed [PW-1:0] fwd_ff, yaw_ff, up_ff, rol_ff;
   logic signed [VW-1:0] t1x_ff, t1y_ff, t2x_ff, t2y_ff;
   init_type vi1_ff, vi2_ff, vi3_ff, vi1_in, vi2_in, vi3_in;
   logic [15:0] tg;

   assign tg = req_tdata[143:128];

   always_ff @(posedge clock) begin
      if (advance) begin
         fx_ff  <= scale({req_tdata[15], req_tdata[15:0]}, tg);
         fz_ff  <= scale({req_tdata[31], req_tdata[31:16]}, tg);
         mx_ff  <= scale(dsum(req_tdata[47:32], req_tdata[63:48]), tg);
         my_ff  <= scale(dsum(req_tdata[79:64], req_tdata[95:80]), tg);
         mz_ff  <= scale(dsum(req_tdata[111:96], req_tdata[127:112]), tg);
         fwd_ff <= gmul(gain_forward_ff, fx_ff);
         yaw_ff <= gmul(gain_yaw_ff, mz_ff);
         up_ff  <= gmul(gain_up_ff, fz_ff);
         rol_ff <= gmul(gain_roll_ff, mx_ff);
         t1x_ff <= rnd14(fwd_ff + yaw_ff);
         t1y_ff <= rnd14(up_ff + rol_ff);
         t2x_ff <= rnd14(fwd_ff - yaw_ff);
         t2y_ff <= rnd14(up_ff - rol_ff);
         vi1_ff <= vi1_in;
         vi2_ff <= vi2_in;
         vi3_ff <= vi3_in;
      end
   end

   // vector components swap: x carries the vertical term
   assign vi1_in = vec_init(CW'(t1y_ff) <<< 8, CW'(t1x_ff) <<< 8);
   assign vi2_in = vec_init(CW'(t2y_ff) <<< 8, CW'(t2x_ff) <<< 8);

   // CORDIC units
   logic signed [CW-1:0] vc1_x, vc2_x, sc_y;
   logic signed [ZW-1:0] vc1_z, vc2_z, ac_z;

   vtm_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b0)) u_vec1 (
      .clock(clock), .en(advance),
      .x_start(vi1_ff.x), .y_start(vi1_ff.y), .z_start(vi1_ff.z),
      .x_end(vc1_x), .y_end(), .z_end(vc1_z)
   );

   vtm_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b0)) u_vec2 (
      .clock(clock), .en(advance),
      .x_start(vi2_ff.x), .y_start(vi2_ff.y), .z_start(vi2_ff.z),
      .x_end(vc2_x), .y_end(), .z_end(vc2_z)
   );

   side_type side_ff [NSTAGE];
   side_type side_in [NSTAGE];

   vtm_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b1)) u_sin (
      .clock(clock), .en(advance),
      .x_start(CW'(GAIN_Q30)), .y_start('0), .z_start(side_ff[S_THR].zs),
      .x_end(), .y_end(sc_y), .z_end()
   );

   vtm_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b0)) u_asin (
      .clock(clock), .en(advance),
      .x_start(vi3_ff.x), .y_start(vi3_ff.y), .z_start(vi3_ff.z),
      .x_end(), .y_end(), .z_end(ac_z)
   );

   // square root, one result bit per stage
   logic [RW-1:0] rn_ff [ROOT_STEPS];
   logic [RW-1:0] rres_ff [ROOT_STEPS];
   logic [RW-1:0] rn_in [ROOT_STEPS];
   logic [RW-1:0] rres_in [ROOT_STEPS];

   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
      logic [RW-1:0] pn, pr, b, t;

      if (j == 0) begin : g_first
         assign pn = side_ff[S_NRAD].n;
         assign pr = '0;
      end else begin : g_next
         assign pn = rn_ff[j-1];
         assign pr = rres_ff[j-1];
      end

      assign b = RW'(1) << (2 * (ROOT_STEPS - 1 - j));
      assign t = pr + b;

      always_comb begin
         if (pn >= t) begin
            rn_in[j] = pn - t;
            rres_in[j] = (pr >> 1) + b;
         end else begin
            rn_in[j] = pn;
            rres_in[j] = pr >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rn_ff[j] <= rn_in[j];
            rres_ff[j] <= rres_in[j];
         end
      end
   end

   assign vi3_in = vec_init($signed(rres_ff[ROOT_STEPS-1][CW-1:0]),
                            CW'(side_ff[S_RTL].a));

   // side data travelling with each request
   logic signed [CW-1:0]  m1, m2;
   logic signed [ZW-1:0]  p1, p2, phi;
   logic signed [ZW:0]    psum;
   logic [MPW:0]          mq1, mq2;
   logic signed [LPW-1:0] lk, ly, lt;
   logic signed [2*AW-1:0] sq64;
   logic signed [AW-1:0]  a_c;

   always_comb begin
      side_in[S_SCALE] = '0;
      for (int k = 1; k < NSTAGE; k++) begin
         side_in[k] = side_ff[k-1];
      end

      side_in[S_PROD].pm = (gmul(gain_pitch_ff, my_ff) + PW'(1)) >>> 1;
      side_in[S_PROD].low = fz_ff < $signed({{(DW - CUTOFF_W){1'b0}}, cutoff_ff});

      side_in[S_SETUP].zero1 = vi1_in.zero;
      side_in[S_SETUP].zero2 = vi2_in.zero;

      m1 = vc1_x;
      m2 = vc2_x;
      p1 = side_ff[S_VCL].zero1 ? '0 : vc1_z;
      p2 = side_ff[S_VCL].zero2 ? '0 : vc2_z;
      psum = {p1[ZW-1], p1} + {p2[ZW-1], p2};
      phi = psum[ZW:1];
      mq1 = mag_prod(m1, side_ff[S_VCL].zero1);
      mq2 = mag_prod(m2, side_ff[S_VCL].zero2);
      side_in[S_MAG].big1 = mq1[MPW];
      side_in[S_MAG].mp1 = mq1[MPW-1:0];
      side_in[S_MAG].big2 = mq2[MPW];
      side_in[S_MAG].mp2 = mq2[MPW-1:0];
      side_in[S_MAG].phi = phi;
      side_in[S_MAG].s1r = PW'(p1) - PW'(phi) - side_ff[S_VCL].pm;
      side_in[S_MAG].s2r = PW'(p2) - PW'(phi) - side_ff[S_VCL].pm;

      side_in[S_THR].m1 = thrust(side_ff[S_MAG].big1, side_ff[S_MAG].mp1);
      side_in[S_THR].m2 = thrust(side_ff[S_MAG].big2, side_ff[S_MAG].mp2);
      side_in[S_THR].s1 = sat16(side_ff[S_MAG].s1r);
      side_in[S_THR].s2 = sat16(side_ff[S_MAG].s2r);
      side_in[S_THR].zs = fold(side_ff[S_MAG].phi);

      lk = LPW'($signed({1'b0, linkage_ratio_ff}));
      ly = LPW'($signed(sc_y[32:0]));
      side_in[S_LPROD].lp = lk * ly;

      lt = (side_ff[S_LPROD].lp + LPW'(16384)) >>> 15;
      if (lt > LPW'(ONE_Q30)) begin
         a_c = ONE_Q30;
      end else if (lt < -LPW'(ONE_Q30)) begin
         a_c = -ONE_Q30;
      end else begin
         a_c = AW'(lt);
      end
      side_in[S_LCLAMP].a = a_c;

      sq64 = (2 * AW)'(side_ff[S_LCLAMP].a) * (2 * AW)'(side_ff[S_LCLAMP].a);
      side_in[S_SQ].sq = sq64[RW-1:0];

      side_in[S_NRAD].n = ONE_Q60 - side_ff[S_SQ].sq;

      side_in[S_ASET].zero3 = vi3_in.zero;
   end

   for (genvar k = 0; k < NSTAGE; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // final servo and output packing
   logic signed [ZW-1:0] asn;
   logic signed [PW-1:0] s3r;
   logic [FIELD_W-1:0]   s3;
   side_type             fin;

   always_comb begin
      fin = side_ff[S_ACL];
      asn = fin.zero3 ? '0 : ac_z;
      s3r = PW'(asn) + PW'(fin.phi) - $signed(PW'({rear_offset_ff, 13'b0}));
      s3 = sat16(s3r);
      if (fin.low) begin
         result = {{(3 * FIELD_W){1'b0}}, fin.m2, fin.m1};
      end else begin
         result = {s3, fin.s2, fin.s1, fin.m2, fin.m1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= v_ff[NSTAGE-1];
         end
      end else if (v_ff[NSTAGE-1] && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= skid_v_ff ? skid_ff : result;
      end else if (!skid_v_ff) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;

endmodule
